FILE: rtl/core/mmc_pkg.sv
// Package for the model matrix compose block: item types, CORDIC constants, atan table.
// No dependencies.
`default_nettype none
package mmc_pkg;
	localparam int ATAN_ENTRIES = 24;
	localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
	localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;
	localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
	localparam logic [1:0]          LAST_ROW    = 2'd3;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} mmc_in_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic signed [31:0] elem0;
		logic signed [31:0] elem1;
		logic signed [31:0] elem2;
		logic signed [31:0] elem3;
		logic               last_row;
	} mmc_out_t;

	// Front to back: reduced angles and negate flags
	typedef struct packed {
		logic signed [33:0] zx;
		logic signed [33:0] zy;
		logic signed [33:0] zz;
		logic               nx;
		logic               ny;
		logic               nz;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} mmc_job_t;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] r;
		begin
			case (i)
				5'd0: r = 34'sh3243F6A8;  5'd1: r = 34'sh1DAC6705;
				5'd2: r = 34'sh0FADBAFC;  5'd3: r = 34'sh07F56EA6;
				5'd4: r = 34'sh03FEAB76;  5'd5: r = 34'sh01FFD55B;
				5'd6: r = 34'sh00FFFAAA;  5'd7: r = 34'sh007FFF55;
				5'd8: r = 34'sh003FFFEA;  5'd9: r = 34'sh001FFFFD;
				5'd10: r = 34'sh000FFFFF; 5'd11: r = 34'sh0007FFFF;
				5'd12: r = 34'sh0003FFFF; 5'd13: r = 34'sh0001FFFF;
				5'd14: r = 34'sh0000FFFF; 5'd15: r = 34'sh00007FFF;
				5'd16: r = 34'sh00003FFF; 5'd17: r = 34'sh00001FFF;
				5'd18: r = 34'sh00000FFF; 5'd19: r = 34'sh000007FF;
				5'd20: r = 34'sh000003FF; 5'd21: r = 34'sh000001FF;
				5'd22: r = 34'sh000000FF; 5'd23: r = 34'sh0000007F;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	// Reduce a Q3.13 angle to Q4.30 within +-pi/2
	function automatic logic [34:0] reduce(input logic signed [15:0] a);
		logic signed [33:0] z;
		logic               n;
		begin
			z = 34'(signed'(a)) <<< 17;
			n = 1'b0;
			if (z > Q30_HALF_PI) begin
				z = z - Q30_PI;
				n = 1'b1;
			end else if (z < -Q30_HALF_PI) begin
				z = z + Q30_PI;
				n = 1'b1;
			end
			return {n, z};
		end
	endfunction

	// Q4.30 product rounded half up
	function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
			input logic signed [33:0] b);
		logic signed [67:0] p;
		begin
			p = 68'(a) * 68'(b) + (68'sd1 <<< 29);
			return 34'(p >>> 30);
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		begin
			if (v > 66'sd2147483647) return 32'h7FFFFFFF;
			else if (v < -66'sd2147483648) return 32'h80000000;
			else return v[31:0];
		end
	endfunction

	// R (Q4.30) times scale (Q16.16), rounded to Q16.16, saturated
	function automatic logic signed [31:0] scaled(input logic signed [33:0] r,
			input logic signed [31:0] sc);
		logic signed [65:0] p;
		begin
			p = 66'(r) * 66'(sc) + (66'sd1 <<< 29);
			return sat32(p >>> 30);
		end
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/mmc_front.sv
// Front part: accepts an item, reduces the three angles, registers the job for the CORDIC.
// Depends on mmc_pkg.
`default_nettype none
module mmc_front import mmc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire mmc_in_t  item,
	output logic          job_valid,
	output mmc_job_t      job
);
	logic [34:0] rx, ry, rz;
	mmc_job_t job_q;
	logic     valid_q;

	assign rx = reduce(item.angle_x);
	assign ry = reduce(item.angle_y);
	assign rz = reduce(item.angle_z);

	// Register classified job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= accept;
	end
	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.zx <= rx[33:0]; job_q.nx <= rx[34];
			job_q.zy <= ry[33:0]; job_q.ny <= ry[34];
			job_q.zz <= rz[33:0]; job_q.nz <= rz[34];
			job_q.pos_x <= item.pos_x; job_q.pos_y <= item.pos_y;
			job_q.pos_z <= item.pos_z;
			job_q.scale_x <= item.scale_x; job_q.scale_y <= item.scale_y;
			job_q.scale_z <= item.scale_z;
		end
	end
	assign job_valid = valid_q;
	assign job = job_q;
endmodule
`default_nettype wire

FILE: rtl/core/mmc_cordic.sv
// Pipelined rotation-mode CORDIC for three angles at once.
// Depends on mmc_pkg.
`default_nettype none
module mmc_cordic import mmc_pkg::*; #(
	parameter int STAGES = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire mmc_job_t in_job,
	output logic          out_valid,
	output mmc_job_t      out_job,
	output logic signed [33:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z
);
	localparam int N = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;

	logic signed [33:0] x_s [0:N][0:2];
	logic signed [33:0] y_s [0:N][0:2];
	logic signed [33:0] z_s [0:N][0:2];
	logic               v_s [0:N];
	mmc_job_t           j_s [0:N];

	assign v_s[0] = in_valid;
	assign j_s[0] = in_job;
	assign z_s[0][0] = in_job.zx;
	assign z_s[0][1] = in_job.zy;
	assign z_s[0][2] = in_job.zz;
	for (genvar a = 0; a < 3; a++) begin : g_init
		assign x_s[0][a] = Q30_GAIN;
		assign y_s[0][a] = '0;
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else v_s[i+1] <= v_s[i];
		end
		always_ff @(posedge clk) begin
			j_s[i+1] <= j_s[i];
		end
		for (genvar a = 0; a < 3; a++) begin : g_ax
			always_ff @(posedge clk) begin
				if (!z_s[i][a][33]) begin
					x_s[i+1][a] <= x_s[i][a] - (y_s[i][a] >>> i);
					y_s[i+1][a] <= y_s[i][a] + (x_s[i][a] >>> i);
					z_s[i+1][a] <= z_s[i][a] - atan_q30(5'(i));
				end else begin
					x_s[i+1][a] <= x_s[i][a] + (y_s[i][a] >>> i);
					y_s[i+1][a] <= y_s[i][a] - (x_s[i][a] >>> i);
					z_s[i+1][a] <= z_s[i][a] + atan_q30(5'(i));
				end
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_job = j_s[N];
	assign cos_x = j_s[N].nx ? -x_s[N][0] : x_s[N][0];
	assign sin_x = j_s[N].nx ? -y_s[N][0] : y_s[N][0];
	assign cos_y = j_s[N].ny ? -x_s[N][1] : x_s[N][1];
	assign sin_y = j_s[N].ny ? -y_s[N][1] : y_s[N][1];
	assign cos_z = j_s[N].nz ? -x_s[N][2] : x_s[N][2];
	assign sin_z = j_s[N].nz ? -y_s[N][2] : y_s[N][2];
endmodule
`default_nettype wire

FILE: rtl/core/mmc_back.sv
// Back part: rotation products, scaling, then four row results per item.
// Depends on mmc_pkg.
`default_nettype none
module mmc_back import mmc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire mmc_job_t in_job,
	input  wire logic signed [33:0] sx, cx, sy, cy, sz, cz,
	output logic          strobe,
	output mmc_out_t      result
);
	// Stage 1: first-level products
	logic v_s1, v_s2, v_s3;
	logic signed [33:0] sysx_s1, sycx_s1, czcy_s1, szcx_s1, szsx_s1, szcy_s1;
	logic signed [33:0] czcx_s1, czsx_s1, cysx_s1, cycx_s1, nsy_s1, cz_s1, sz_s1;
	mmc_job_t j_s1, j_s2, j_s3;
	always_ff @(posedge clk) begin
		sysx_s1 <= mul30(sy, sx); sycx_s1 <= mul30(sy, cx);
		czcy_s1 <= mul30(cz, cy); szcx_s1 <= mul30(sz, cx);
		szsx_s1 <= mul30(sz, sx); szcy_s1 <= mul30(sz, cy);
		czcx_s1 <= mul30(cz, cx); czsx_s1 <= mul30(cz, sx);
		cysx_s1 <= mul30(cy, sx); cycx_s1 <= mul30(cy, cx);
		nsy_s1 <= -sy; cz_s1 <= cz; sz_s1 <= sz; j_s1 <= in_job;
	end

	// Stage 2: second-level products and sums
	logic signed [33:0] r_s2 [0:8];
	always_ff @(posedge clk) begin
		r_s2[0] <= czcy_s1;
		r_s2[1] <= mul30(cz_s1, sysx_s1) - szcx_s1;
		r_s2[2] <= mul30(cz_s1, sycx_s1) + szsx_s1;
		r_s2[3] <= szcy_s1;
		r_s2[4] <= mul30(sz_s1, sysx_s1) + czcx_s1;
		r_s2[5] <= mul30(sz_s1, sycx_s1) - czsx_s1;
		r_s2[6] <= nsy_s1;
		r_s2[7] <= cysx_s1;
		r_s2[8] <= cycx_s1;
		j_s2 <= j_s1;
	end

	// Stage 3: scale the columns
	logic signed [31:0] e_s3 [0:8];
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			e_s3[3*k+0] <= scaled(r_s2[3*k+0], j_s2.scale_x);
			e_s3[3*k+1] <= scaled(r_s2[3*k+1], j_s2.scale_y);
			e_s3[3*k+2] <= scaled(r_s2[3*k+2], j_s2.scale_z);
		end
		j_s3 <= j_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	// Output sequencer: latch a finished matrix, emit rows 0..3
	logic [1:0]         row_q;
	logic               busy_q;
	logic               idle;
	logic signed [31:0] m_q [0:8];
	logic signed [31:0] p_q [0:2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			busy_q <= 1'b0;
		end else if (v_s3) begin
			busy_q <= 1'b1;
			row_q <= '0;
		end else if (busy_q) begin
			row_q <= row_q + 2'd1;
			if (row_q == LAST_ROW) busy_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (v_s3) begin
			m_q <= e_s3;
			p_q[0] <= j_s3.pos_x; p_q[1] <= j_s3.pos_y; p_q[2] <= j_s3.pos_z;
		end
	end

	always_comb begin
		result.row_index = row_q;
		result.last_row = (row_q == LAST_ROW);
		case (row_q)
			2'd0: begin
				result.elem0 = m_q[0]; result.elem1 = m_q[1];
				result.elem2 = m_q[2]; result.elem3 = p_q[0];
			end
			2'd1: begin
				result.elem0 = m_q[3]; result.elem1 = m_q[4];
				result.elem2 = m_q[5]; result.elem3 = p_q[1];
			end
			2'd2: begin
				result.elem0 = m_q[6]; result.elem1 = m_q[7];
				result.elem2 = m_q[8]; result.elem3 = p_q[2];
			end
			default: begin
				result.elem0 = '0; result.elem1 = '0;
				result.elem2 = '0; result.elem3 = ONE_Q16;
			end
		endcase
	end
	assign strobe = busy_q;
	assign idle = !(v_s1 || v_s2 || v_s3 || busy_q);

	// A new matrix never lands mid-burst
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (!busy_q || row_q == LAST_ROW)) else $error("row burst overrun");
	a_rows_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && row_q != LAST_ROW) |=> (busy_q && row_q == $past(row_q) + 2'd1))
		else $error("row order broken");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> !strobe) else $error("strobe while idle");
endmodule
`default_nettype wire

FILE: rtl/core/model_matrix_compose_unit.sv
// Top level of the model matrix compose block: front, CORDIC pipeline, back.
// Depends on mmc_pkg, mmc_front, mmc_cordic, mmc_back.
`default_nettype none
// After each accepted start, busy stays high while the spacing counter gap_q
// runs down, and a start in that time is not taken. The CORDIC runs
// CORDIC_STAGES micro-rotations, capped at 24. Results appear as four strobed rows
// in consecutive cycles, rows 0 to 3, last_row on row 3. The receiver cannot
// stall; every strobed row is final.
module model_matrix_compose_unit import mmc_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire mmc_in_t  item,
	output logic          strobe,
	output mmc_out_t      result
);
	logic [1:0] gap_q;
	logic       accept;
	logic       job_valid, c_valid;
	mmc_job_t   job, c_job;
	logic signed [33:0] sx, cx, sy, cy, sz, cz;

	assign accept = start && !busy;
	assign busy = (gap_q != 2'd0);

	// Spacing counter: holds busy after each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gap_q <= '0;
		else if (accept) gap_q <= 2'd3;
		else if (gap_q != 2'd0) gap_q <= gap_q - 2'd1;
	end

	mmc_front u_front (.clk, .arst_n, .accept, .item, .job_valid, .job);
	mmc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (.clk, .arst_n,
		.in_valid(job_valid), .in_job(job), .out_valid(c_valid), .out_job(c_job),
		.sin_x(sx), .cos_x(cx), .sin_y(sy), .cos_y(cy), .sin_z(sz), .cos_z(cz));
	mmc_back u_back (.clk, .arst_n, .in_valid(c_valid), .in_job(c_job),
		.sx, .cx, .sy, .cy, .sz, .cz, .strobe, .result);
endmodule
`default_nettype wire
